// ===== sv/multicore_priority_feedback_scheduler_macros.svh =====
// Assertion macros shared by the scheduler RTL.
`ifndef MULTICORE_PRIORITY_FEEDBACK_SCHEDULER_MACROS_SVH
`define MULTICORE_PRIORITY_FEEDBACK_SCHEDULER_MACROS_SVH

// Same-cycle implication, checked on the rising edge while out of reset.
`define MPFS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on the rising edge while out of reset.
`define MPFS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/mpfs_pkg.sv =====
// Types, constants and helpers of the scheduling policy engine.
`default_nettype none
package mpfs_pkg;
	localparam int SLOTS  = 64;
	localparam int CPUS   = 8;
	localparam int QUEUES = 16;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int CPU_W  = $clog2(CPUS);
	localparam int CNT_W  = CPU_W + 1;
	localparam int PRI_W  = $clog2(QUEUES);
	localparam int LOAD_W = 7;
	localparam logic [LOAD_W-1:0] LOAD_MAX = '1;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;

	typedef enum logic [2:0] {
		CMD_START    = 3'd0,
		CMD_INHERIT  = 3'd1,
		CMD_STOP     = 3'd2,
		CMD_QUANTUM  = 3'd3,
		CMD_NICE     = 3'd4,
		CMD_BALANCE  = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BAD_PRI = 2'd1,
		ST_UNUSED  = 2'd2,
		ST_BUSY    = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CPU_COUNT    = 3'd0,
		REG_BOOT_CPU     = 3'd1,
		REG_USER_QUEUE   = 3'd2,
		REG_LOWEST_QUEUE = 3'd3,
		REG_DEFAULT_SLICE = 3'd4,
		REG_SM_SLOT      = 3'd5
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_LOAD, S_DROP, S_CHOOSE, S_SCAN,
		S_ADD, S_PUSH, S_RET, S_BAL_CHK, S_FIN
	} fsm_t;

	typedef struct packed {
		logic [PRI_W-1:0] pri;
		logic [PRI_W-1:0] max_pri;
		logic [15:0]      slice;
		logic [CPU_W-1:0] cpu;
		logic             sys;
	} entry_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [SLOT_W-1:0] slot;
		logic [3:0]        pri;
		logic [15:0]       slice;
		logic [2:0]        cpu;
		logic              niced;
		logic              scheduled;
		logic              last;
	} rec_t;

	function automatic rec_t make_rec(input status_t st, input logic [SLOT_W-1:0] s,
			input logic placed, input entry_t e, input logic [3:0] uq);
		rec_t r;
		r = '0;
		r.status = st;
		r.slot = s;
		if (placed) begin
			r.pri = 4'(e.pri);
			r.slice = e.slice;
			r.cpu = 3'(e.cpu);
			r.niced = (4'(e.max_pri) > uq);
			r.scheduled = 1'b1;
		end
		return r;
	endfunction
endpackage
`default_nettype wire

// ===== sv/mpfs_if.sv =====
// Request, result and configuration channel interfaces.
`default_nettype none
interface mpfs_cmd_if;
	logic       valid;
	logic       ready;
	logic [2:0] command;
	logic [5:0] slot;
	logic [5:0] parent_slot;
	logic [4:0] requested_priority;
	logic [15:0] quantum;
	modport source (output valid, command, slot, parent_slot, requested_priority, quantum,
		input ready);
	modport sink (input valid, command, slot, parent_slot, requested_priority, quantum,
		output ready);
endinterface

interface mpfs_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [5:0]  slot_out;
	logic [3:0]  priority_out;
	logic [15:0] slice_out;
	logic [2:0]  cpu_out;
	logic        niced;
	logic        scheduled;
	logic        last;
	modport source (output valid, status, slot_out, priority_out, slice_out, cpu_out,
		niced, scheduled, last, input ready);
	modport sink (input valid, status, slot_out, priority_out, slice_out, cpu_out,
		niced, scheduled, last, output ready);
endinterface

interface mpfs_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] wdata;
	modport source (output valid, index, wdata, input ready);
	modport sink (input valid, index, wdata, output ready);
endinterface
`default_nettype wire

// ===== sv/multicore_priority_feedback_scheduler.sv =====
// Scheduling policy engine: slot table memory, per-CPU loads and command sequencer.
// One request at a time; the time from acceptance to a command's result is set mostly
// by the CPU load scan, one counter per cycle over up to eight CPUs.
// A balance tick walks all 64 slots, skipping over idle slots and making a full
// read-modify-write placement for each raised process. Reset clears in-use marks,
// loads, configuration and control registers; table and payload data stay undefined.
`default_nettype none
`include "multicore_priority_feedback_scheduler_macros.svh"
module multicore_priority_feedback_scheduler (
	input  wire logic clk,
	input  wire logic arst_n,
	mpfs_cmd_if.sink   cmd,
	mpfs_rsp_if.source rsp,
	mpfs_cfg_if.sink   cfg
);
	import mpfs_pkg::*;

	// Configuration registers.
	logic [3:0]  cpu_count_q;
	logic [2:0]  boot_cpu_q;
	logic [3:0]  user_queue_q;
	logic [3:0]  lowest_queue_q;
	logic [15:0] default_slice_q;
	logic [5:0]  sm_slot_q;

	// The default slice register is written by configuration but never read,
	// so no record ever shows it.
	logic unused_slice;
	assign unused_slice = ^default_slice_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpu_count_q <= 4'd1;
			boot_cpu_q <= 3'd0;
			user_queue_q <= 4'd7;
			lowest_queue_q <= 4'd14;
			default_slice_q <= 16'd200;
			sm_slot_q <= 6'd0;
		end else if (cfg.valid) begin
			case (reg_idx_t'(cfg.index))
				REG_CPU_COUNT:     cpu_count_q <= cfg.wdata[3:0];
				REG_BOOT_CPU:      boot_cpu_q <= cfg.wdata[2:0];
				REG_USER_QUEUE:    user_queue_q <= cfg.wdata[3:0];
				REG_LOWEST_QUEUE:  lowest_queue_q <= cfg.wdata[3:0];
				REG_DEFAULT_SLICE: default_slice_q <= cfg.wdata;
				REG_SM_SLOT:       sm_slot_q <= cfg.wdata[5:0];
				default: ;
			endcase
		end
	end

	// A count of zero behaves as one CPU and anything above the CPU total as all CPUs.
	logic [CNT_W-1:0] eff_n;
	logic [CPU_W-1:0] eff_boot;
	always_comb begin
		if (cpu_count_q == 4'd0) begin
			eff_n = CNT_W'(1);
		end else if ({1'b0, cpu_count_q} > 5'(CPUS)) begin
			eff_n = CNT_W'(CPUS);
		end else begin
			eff_n = CNT_W'(cpu_count_q);
		end
		eff_boot = CPU_W'(boot_cpu_q);
	end

	// Accepted request held for the whole command.
	cmd_t              cmd_q;
	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W-1:0] par_q;
	logic [4:0]        req_q;
	logic [15:0]       quantum_q;

	fsm_t state_q, state_d;
	logic cmd_acc;
	assign cmd.ready = (state_q == S_IDLE);
	assign cmd_acc = cmd.valid && cmd.ready;

	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			cmd_q <= cmd_t'(cmd.command);
			slot_q <= cmd.slot;
			par_q <= cmd.parent_slot;
			req_q <= cmd.requested_priority;
			quantum_q <= cmd.quantum;
		end
	end

	// Slot table memory with registered read; in-use marks live in flip-flops so
	// that reset clears them at once.
	entry_t            mem [SLOTS];
	entry_t            rd_s1;
	logic [SLOT_W-1:0] rd_addr;
	logic              mem_we;
	logic [SLOT_W-1:0] wr_addr;
	entry_t            wr_data;
	logic [SLOTS-1:0]  in_use_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_s1 <= mem[rd_addr];
	end

	// Per-CPU load counters; every access goes through one index chosen by state.
	logic [LOAD_W-1:0] core_load_q [CPUS];
	logic [LOAD_W-1:0] core_sys_load_q [CPUS];
	logic [CPU_W-1:0]  cidx;
	logic [LOAD_W-1:0] load_rd;
	logic [LOAD_W-1:0] sys_rd;
	assign load_rd = core_load_q[cidx];
	assign sys_rd = core_sys_load_q[cidx];

	// Working registers of the command in flight.
	entry_t            w_q;
	logic [SLOT_W-1:0] cur_slot_q;
	logic [CPU_W-1:0]  best_q;
	logic [LOAD_W-1:0] best_load_q;
	logic [CPU_W-1:0]  scan_c_q;
	logic [SLOT_W-1:0] bal_i_q;
	rec_t              nr_q;
	rec_t              rec_q;
	logic              rec_have_q;
	rec_t              out_q;
	logic              out_v_q;
	logic              out_free;
	logic              out_load;

	assign out_free = !out_v_q || rsp.ready;
	// The held record moves to the output register, once that is free, when a newer one
	// arrives or when the command closes.
	assign out_load = (state_q == S_PUSH || state_q == S_FIN) && rec_have_q && out_free;

	// Decode-time checks; a failure produces a record holding only status and slot.
	logic    dec_err;
	status_t dec_st;
	always_comb begin
		dec_err = 1'b0;
		dec_st = ST_OK;
		case (cmd_q)
			CMD_START, CMD_INHERIT: begin
				if (in_use_q[slot_q]) begin
					dec_err = 1'b1;
					dec_st = ST_BUSY;
				end else if (req_q[4]) begin
					dec_err = 1'b1;
					dec_st = ST_BAD_PRI;
				end else if (cmd_q == CMD_INHERIT && !in_use_q[par_q]) begin
					dec_err = 1'b1;
					dec_st = ST_UNUSED;
				end
			end
			CMD_STOP, CMD_QUANTUM, CMD_NICE: begin
				if (!in_use_q[slot_q]) begin
					dec_err = 1'b1;
					dec_st = ST_UNUSED;
				end else if (cmd_q == CMD_NICE && req_q[4]) begin
					dec_err = 1'b1;
					dec_st = ST_BAD_PRI;
				end
			end
			default: ;
		endcase
	end

	// Next state and the strobes that go with it.
	logic bal_raise;
	logic scan_done;
	logic bal_end;
	assign bal_raise = rd_s1.pri > rd_s1.max_pri;
	assign scan_done = ({1'b0, scan_c_q} == eff_n - CNT_W'(1));
	assign bal_end = (bal_i_q == SLOT_W'(SLOTS - 1));

	always_comb begin
		state_d = state_q;
		rd_addr = slot_q;
		cidx = w_q.cpu;
		mem_we = 1'b0;
		wr_addr = cur_slot_q;
		wr_data = w_q;
		wr_data.cpu = best_q;
		case (state_q)
			S_IDLE: begin
				if (cmd_acc) state_d = S_DECODE;
			end
			S_DECODE: begin
				rd_addr = (cmd_q == CMD_INHERIT) ? par_q : slot_q;
				if (cmd_q == CMD_BALANCE) begin
					state_d = S_BAL_CHK;
				end else if (cmd_q != CMD_START && cmd_q != CMD_INHERIT &&
						cmd_q != CMD_STOP && cmd_q != CMD_QUANTUM && cmd_q != CMD_NICE) begin
					state_d = S_FIN;
				end else if (dec_err) begin
					state_d = S_PUSH;
				end else begin
					state_d = S_LOAD;
				end
			end
			S_BAL_CHK: begin
				rd_addr = bal_i_q;
				if (in_use_q[bal_i_q]) state_d = S_LOAD;
				else if (bal_end) state_d = S_FIN;
			end
			S_LOAD: begin
				case (cmd_q)
					CMD_START, CMD_INHERIT: state_d = (par_q == slot_q) ? S_ADD : S_CHOOSE;
					CMD_BALANCE: state_d = bal_raise ? S_DROP : S_RET;
					default: state_d = S_DROP;
				endcase
			end
			S_DROP: begin
				cidx = w_q.cpu;
				state_d = (cmd_q == CMD_STOP) ? S_PUSH : S_CHOOSE;
			end
			S_CHOOSE: begin
				cidx = eff_boot;
				if (eff_n == CNT_W'(1) || w_q.sys) state_d = S_ADD;
				else state_d = S_SCAN;
			end
			S_SCAN: begin
				cidx = scan_c_q;
				if (scan_done) state_d = S_ADD;
			end
			S_ADD: begin
				cidx = best_q;
				mem_we = 1'b1;
				state_d = S_PUSH;
			end
			S_PUSH: begin
				if (!rec_have_q || out_free) state_d = S_RET;
			end
			S_RET: begin
				if (cmd_q == CMD_BALANCE && !bal_end) state_d = S_BAL_CHK;
				else state_d = S_FIN;
			end
			S_FIN: begin
				if (!rec_have_q || out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control state: in-use marks, loads, record bookkeeping, output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
			rec_have_q <= 1'b0;
			out_v_q <= 1'b0;
			for (int c = 0; c < CPUS; c++) begin
				core_load_q[c] <= '0;
				core_sys_load_q[c] <= '0;
			end
		end else begin
			if (out_load) out_v_q <= 1'b1;
			else if (out_v_q && rsp.ready) out_v_q <= 1'b0;
			case (state_q)
				S_DROP: begin
					if (load_rd != '0) core_load_q[cidx] <= load_rd - LOAD_W'(1);
					if (w_q.sys && sys_rd != '0) core_sys_load_q[cidx] <= sys_rd - LOAD_W'(1);
					if (cmd_q == CMD_STOP) in_use_q[cur_slot_q] <= 1'b0;
				end
				S_ADD: begin
					if (load_rd != LOAD_MAX) core_load_q[cidx] <= load_rd + LOAD_W'(1);
					if (w_q.sys && sys_rd != LOAD_MAX) core_sys_load_q[cidx] <= sys_rd + LOAD_W'(1);
					in_use_q[cur_slot_q] <= 1'b1;
				end
				S_PUSH: begin
					// A held record goes out marked not-last once a newer one exists.
					if (!rec_have_q) rec_have_q <= 1'b1;
				end
				S_FIN: begin
					if (out_load) rec_have_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// Entry as updated by the command, formed from the table read.
	entry_t w_load;
	always_comb begin
		w_load = rd_s1;
		case (cmd_q)
			CMD_START, CMD_INHERIT: begin
				w_load.sys = (par_q == sm_slot_q);
				w_load.max_pri = req_q[PRI_W-1:0];
				w_load.pri = (cmd_q == CMD_START) ? req_q[PRI_W-1:0] : rd_s1.pri;
				w_load.slice = (cmd_q == CMD_START) ? quantum_q : rd_s1.slice;
			end
			CMD_QUANTUM: begin
				if (rd_s1.pri < lowest_queue_q) w_load.pri = rd_s1.pri + PRI_W'(1);
			end
			CMD_NICE: begin
				w_load.pri = req_q[PRI_W-1:0];
				w_load.max_pri = req_q[PRI_W-1:0];
			end
			CMD_BALANCE: begin
				w_load.pri = rd_s1.pri - PRI_W'(1);
			end
			default: ;
		endcase
	end

	// The held record carries the last mark only when the command closes.
	rec_t rec_out;
	always_comb begin
		rec_out = rec_q;
		rec_out.last = (state_q == S_FIN);
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_DECODE: begin
				cur_slot_q <= slot_q;
				nr_q <= make_rec(dec_st, slot_q, 1'b0, w_q, user_queue_q);
				bal_i_q <= '0;
			end
			S_BAL_CHK: begin
				cur_slot_q <= bal_i_q;
				if (!in_use_q[bal_i_q] && !bal_end) bal_i_q <= bal_i_q + SLOT_W'(1);
			end
			S_LOAD: begin
				w_q <= w_load;
				best_q <= eff_boot;
			end
			S_DROP: begin
				nr_q <= make_rec(ST_OK, cur_slot_q, 1'b0, w_q, user_queue_q);
			end
			S_CHOOSE: begin
				best_q <= eff_boot;
				best_load_q <= load_rd;
				scan_c_q <= '0;
			end
			S_SCAN: begin
				if (load_rd < best_load_q) begin
					best_q <= scan_c_q;
					best_load_q <= load_rd;
				end
				scan_c_q <= scan_c_q + CPU_W'(1);
			end
			S_ADD: begin
				nr_q <= make_rec(ST_OK, cur_slot_q, 1'b1, wr_data, user_queue_q);
			end
			S_PUSH: begin
				if (!rec_have_q) begin
					rec_q <= nr_q;
				end else if (out_free) begin
					out_q <= rec_out;
					rec_q <= nr_q;
				end
			end
			S_RET: begin
				if (cmd_q == CMD_BALANCE && !bal_end) bal_i_q <= bal_i_q + SLOT_W'(1);
			end
			S_FIN: begin
				if (rec_have_q && out_free) out_q <= rec_out;
			end
			default: ;
		endcase
	end

	assign rsp.valid = out_v_q;
	assign rsp.status = out_q.status;
	assign rsp.slot_out = out_q.slot;
	assign rsp.priority_out = out_q.pri;
	assign rsp.slice_out = out_q.slice;
	assign rsp.cpu_out = out_q.cpu;
	assign rsp.niced = out_q.niced;
	assign rsp.scheduled = out_q.scheduled;
	assign rsp.last = out_q.last;

	// A request is only taken while no other command is in flight.
	`MPFS_ASSERT_NEXT(a_busy_after_accept, cmd_acc, state_q == S_DECODE && !cmd.ready,
		"request accepted but sequencer did not start")
	// The load scan never reaches a CPU outside the active count.
	`MPFS_ASSERT_NOW(a_scan_in_range, state_q == S_SCAN, {1'b0, scan_c_q} < eff_n,
		"load scan beyond active CPU count")
	// Closing a command with a held record always releases it as the final result.
	`MPFS_ASSERT_NEXT(a_last_released, state_q == S_FIN && rec_have_q && out_free,
		rsp.valid && rsp.last && !rec_have_q, "final record not released")
	// A table write marks its slot in use.
	`MPFS_ASSERT_NEXT(a_write_marks_use, mem_we, in_use_q[$past(wr_addr)],
		"table entry written without in-use mark")
endmodule
`default_nettype wire
